@@ hdl/gkeg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkeg_pkg
// Shared types, codes and helper functions for the gamepad keystroke event
// generator.
// ----------------------------------------------------------------------------
package gkeg_pkg;

   localparam int BUTTON_W    = 14;
   localparam int TRIGGER_W   = 8;
   localparam int STICK_W     = 16;
   localparam int STICK_THR_W = 15;
   localparam int KEY_W       = 5;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 15;
   localparam int REQ_DATA_W  = 96;
   localparam int RSP_DATA_W  = 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_STICK_THR = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TRIG_THR  = 1'd1;

   localparam logic [STICK_THR_W-1:0] STICK_THR_RESET = 15'd20000;
   localparam logic [TRIGGER_W-1:0]   TRIG_THR_RESET  = 8'd30;

   localparam logic [1:0] AX_OFF  = 2'd0;
   localparam logic [1:0] AX_LOW  = 2'd1;
   localparam logic [1:0] AX_HIGH = 2'd2;

   localparam logic [KEY_W-1:0] KEY_LT          = 5'd14;
   localparam logic [KEY_W-1:0] KEY_RT          = 5'd15;
   localparam logic [KEY_W-1:0] KEY_LSTICK_BASE = 5'd16;
   localparam logic [KEY_W-1:0] KEY_RSTICK_BASE = 5'd24;

   localparam logic [2:0] DIR_UP         = 3'd0;
   localparam logic [2:0] DIR_DOWN       = 3'd1;
   localparam logic [2:0] DIR_RIGHT      = 3'd2;
   localparam logic [2:0] DIR_LEFT       = 3'd3;
   localparam logic [2:0] DIR_UP_LEFT    = 3'd4;
   localparam logic [2:0] DIR_UP_RIGHT   = 3'd5;
   localparam logic [2:0] DIR_DOWN_RIGHT = 3'd6;
   localparam logic [2:0] DIR_DOWN_LEFT  = 3'd7;

   typedef struct packed {
      logic       fire;
      logic [2:0] dir;
      logic       release_key;
      logic [3:0] next_axes;
   } stick_result_type;

   function automatic logic [1:0] quantize(input logic [STICK_W-1:0] v,
                                           input logic [STICK_THR_W-1:0] t);
      logic signed [STICK_W:0] sv;
      logic signed [STICK_W:0] st;
      sv = $signed({v[STICK_W-1], v});
      st = $signed({2'b00, t});
      if (sv > st) begin
         return AX_HIGH;
      end else if (sv < -st) begin
         return AX_LOW;
      end
      return AX_OFF;
   endfunction

   function automatic logic [2:0] dir_offset(input logic [3:0] axes);
      logic [1:0] x;
      logic [1:0] y;
      x = axes[1:0];
      y = axes[3:2];
      if (y == AX_HIGH) begin
         return (x == AX_OFF) ? DIR_UP : (x == AX_LOW) ? DIR_UP_LEFT : DIR_UP_RIGHT;
      end else if (y == AX_LOW) begin
         return (x == AX_OFF) ? DIR_DOWN :
                (x == AX_LOW) ? DIR_DOWN_LEFT : DIR_DOWN_RIGHT;
      end
      return (x == AX_LOW) ? DIR_LEFT : DIR_RIGHT;
   endfunction

   function automatic stick_result_type stick_eval(input logic [3:0] last_axes,
                                                   input logic [3:0] cur_axes);
      stick_result_type r;
      logic             cur_on;
      logic             last_on;
      logic [2:0]       cur_d;
      logic [2:0]       last_d;
      cur_on  = (cur_axes != 4'd0);
      last_on = (last_axes != 4'd0);
      cur_d   = cur_on ? dir_offset(cur_axes) : DIR_UP;
      last_d  = last_on ? dir_offset(last_axes) : DIR_UP;
      r.fire        = 1'b0;
      r.dir         = DIR_UP;
      r.release_key = 1'b0;
      r.next_axes   = cur_axes;
      if ((cur_on != last_on) || (cur_on && (cur_d != last_d))) begin
         r.fire = 1'b1;
         if (last_on) begin
            r.dir         = last_d;
            r.release_key = 1'b1;
            r.next_axes   = 4'd0;
         end else begin
            r.dir = cur_d;
         end
      end
      return r;
   endfunction

endpackage

@@ hdl/gamepad_keystroke_event_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_keystroke_event_generator
// Turns gamepad snapshots into at most one key event per poll.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one snapshot per beat; rsp_* returns exactly one result
//   beat per request beat, in order. rsp_tdata[0] flags whether a key event
//   is present; with no event the code and release bits are zero.
//   csr_* writes the stick threshold (index 0) and the trigger threshold
//   (index 1); write only while no snapshot is in flight.
// Pipeline and throughput:
//   A beat passes a snapshot register and then a result register (two
//   register stages) on its way to rsp_*. One snapshot per cycle is
//   sustained while rsp_tready is high; the compare, priority pick and state
//   update all fit in the one combinational stage between the two registers.
// Reset:
//   Thresholds return to 20000 and 30, all buttons read released, triggers
//   off and sticks centered. Both stages empty.
// Stall:
//   While rsp_tready is low the result holds, the snapshot stage holds one
//   more beat, and then req_tready drops.
// ----------------------------------------------------------------------------
module gamepad_keystroke_event_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // button_bits[13:0], left_trigger[21:14], right_trigger[29:22],
   // left_stick_x[45:30], left_stick_y[61:46], right_stick_x[77:62],
   // right_stick_y[93:78], zero pad[95:94]
   input  logic [gkeg_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // event_valid[0], key_code[5:1], key_release[6], zero pad[7]
   output logic [gkeg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [gkeg_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [gkeg_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gkeg_pkg::*;

   logic [STICK_THR_W-1:0] stick_thr_ff;
   logic [TRIGGER_W-1:0]   trig_thr_ff;

   logic                   snap_valid_ff;
   logic [BUTTON_W-1:0]    snap_buttons_ff;
   logic [TRIGGER_W-1:0]   snap_lt_ff;
   logic [TRIGGER_W-1:0]   snap_rt_ff;
   logic [STICK_W-1:0]     snap_lsx_ff;
   logic [STICK_W-1:0]     snap_lsy_ff;
   logic [STICK_W-1:0]     snap_rsx_ff;
   logic [STICK_W-1:0]     snap_rsy_ff;

   logic [BUTTON_W-1:0]    last_buttons_ff;
   logic                   last_lt_on_ff;
   logic                   last_rt_on_ff;
   logic [3:0]             last_ls_ff;
   logic [3:0]             last_rs_ff;

   logic [BUTTON_W-1:0]    last_buttons_in;
   logic                   last_lt_on_in;
   logic                   last_rt_on_in;
   logic [3:0]             last_ls_in;
   logic [3:0]             last_rs_in;

   logic                   rsp_valid_ff;
   logic                   evt_valid_ff;
   logic [KEY_W-1:0]       key_code_ff;
   logic                   key_release_ff;

   logic                   evt_valid_in;
   logic [KEY_W-1:0]       key_code_in;
   logic                   key_release_in;

   logic                   advance;
   logic [BUTTON_W-1:0]    diff;
   logic [3:0]             btn_idx;
   logic                   lt_on;
   logic                   rt_on;
   logic [3:0]             ls_axes;
   logic [3:0]             rs_axes;
   stick_result_type       ls_res;
   stick_result_type       rs_res;

   assign advance    = snap_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !snap_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, key_release_ff, key_code_ff, evt_valid_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         stick_thr_ff <= STICK_THR_RESET;
         trig_thr_ff  <= TRIG_THR_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_STICK_THR: stick_thr_ff <= csr_wdata;
            CSR_TRIG_THR:  trig_thr_ff  <= csr_wdata[TRIGGER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (req_tready) begin
         snap_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         snap_buttons_ff <= req_tdata[13:0];
         snap_lt_ff      <= req_tdata[21:14];
         snap_rt_ff      <= req_tdata[29:22];
         snap_lsx_ff     <= req_tdata[45:30];
         snap_lsy_ff     <= req_tdata[61:46];
         snap_rsx_ff     <= req_tdata[77:62];
         snap_rsy_ff     <= req_tdata[93:78];
      end
   end

   always_comb begin
      diff    = snap_buttons_ff ^ last_buttons_ff;
      btn_idx = 4'd0;
      for (int i = BUTTON_W - 1; i >= 0; i--) begin
         if (diff[i]) begin
            btn_idx = 4'(i);
         end
      end
      lt_on   = (snap_lt_ff > trig_thr_ff);
      rt_on   = (snap_rt_ff > trig_thr_ff);
      ls_axes = {quantize(snap_lsy_ff, stick_thr_ff), quantize(snap_lsx_ff, stick_thr_ff)};
      rs_axes = {quantize(snap_rsy_ff, stick_thr_ff), quantize(snap_rsx_ff, stick_thr_ff)};
      ls_res  = stick_eval(last_ls_ff, ls_axes);
      rs_res  = stick_eval(last_rs_ff, rs_axes);

      last_buttons_in = last_buttons_ff;
      last_lt_on_in   = last_lt_on_ff;
      last_rt_on_in   = last_rt_on_ff;
      last_ls_in      = last_ls_ff;
      last_rs_in      = last_rs_ff;
      evt_valid_in    = 1'b0;
      key_code_in     = '0;
      key_release_in  = 1'b0;

      if (diff != '0) begin
         evt_valid_in             = 1'b1;
         key_code_in              = {1'b0, btn_idx};
         key_release_in           = !snap_buttons_ff[btn_idx];
         last_buttons_in[btn_idx] = !last_buttons_ff[btn_idx];
      end else if (lt_on != last_lt_on_ff) begin
         evt_valid_in   = 1'b1;
         key_code_in    = KEY_LT;
         key_release_in = !lt_on;
         last_lt_on_in  = lt_on;
      end else if (rt_on != last_rt_on_ff) begin
         evt_valid_in   = 1'b1;
         key_code_in    = KEY_RT;
         key_release_in = !rt_on;
         last_rt_on_in  = rt_on;
      end else begin
         last_ls_in = ls_res.next_axes;
         if (ls_res.fire) begin
            evt_valid_in   = 1'b1;
            key_code_in    = KEY_LSTICK_BASE + {2'b00, ls_res.dir};
            key_release_in = ls_res.release_key;
         end else begin
            last_rs_in = rs_res.next_axes;
            if (rs_res.fire) begin
               evt_valid_in   = 1'b1;
               key_code_in    = KEY_RSTICK_BASE + {2'b00, rs_res.dir};
               key_release_in = rs_res.release_key;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_buttons_ff <= '0;
         last_lt_on_ff   <= 1'b0;
         last_rt_on_ff   <= 1'b0;
         last_ls_ff      <= 4'd0;
         last_rs_ff      <= 4'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (advance) begin
            last_buttons_ff <= last_buttons_in;
            last_lt_on_ff   <= last_lt_on_in;
            last_rt_on_ff   <= last_rt_on_in;
            last_ls_ff      <= last_ls_in;
            last_rs_ff      <= last_rs_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         evt_valid_ff   <= evt_valid_in;
         key_code_ff    <= key_code_in;
         key_release_ff <= key_release_in;
      end
   end

`ifndef SYNTH
   a_idle_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !evt_valid_ff |-> (key_code_ff == '0) && !key_release_ff)
      else $error("result without event carries nonzero fields");

   a_button_single_toggle: assert property (@(posedge clock) disable iff (reset)
      advance && (diff != '0) |=>
         $countones(last_buttons_ff ^ $past(last_buttons_ff)) == 1)
      else $error("button event did not toggle exactly one stored bit");

   a_stick_axes_legal: assert property (@(posedge clock) disable iff (reset)
      (last_ls_ff[1:0] != 2'd3) && (last_ls_ff[3:2] != 2'd3) &&
      (last_rs_ff[1:0] != 2'd3) && (last_rs_ff[3:2] != 2'd3))
      else $error("stored stick axis holds an illegal code");

   a_snap_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      snap_valid_ff && !advance |=> snap_valid_ff && $stable(snap_buttons_ff))
      else $error("pending snapshot lost during stall");
`endif

endmodule
